// ===== hw/rtl/fls_pkg.sv =====
package fls_pkg;

   // Field widths.
   localparam int FREQ_W  = 22;
   localparam int ROC_W   = 32;
   localparam int COUNT_W = 16;
   localparam int MASK_W  = 8;
   localparam int SHED_W  = 4;
   localparam int STATE_W = 2;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // Number of switchable loads.
   localparam int NUM_LOADS = 8;

   // Serial arithmetic: one quotient bit and one multiplier bit per cycle.
   localparam int DIV_STEPS = FREQ_W;
   localparam int MUL_STEPS = FREQ_W;
   localparam int STEP_W    = $clog2(FREQ_W);
   localparam int PROD_W    = 2 * FREQ_W + 2;
   localparam int ROC_SHIFT = 8;

   // 16000 Hz in units of 1/256 Hz.
   localparam logic [FREQ_W-1:0] DIVIDEND = FREQ_W'(4096000);

   // Register reset values: 43.7 Hz and 0.6 Hz/s in 1/256 units.
   localparam logic [FREQ_W-1:0] FREQ_THR_RESET = FREQ_W'(11187);
   localparam logic [ROC_W-1:0]  ROC_THR_RESET  = ROC_W'(154);

   // Register index, taken from the byte address.
   localparam logic REG_FREQ_THR = 1'b0;
   localparam logic REG_ROC_THR  = 1'b1;

   // Request kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TIMER  = 1'b1;

   typedef enum logic [STATE_W-1:0] {
      ST_STABLE    = 2'd0,
      ST_SHED      = 2'd1,
      ST_MONITOR   = 2'd2,
      ST_RECONNECT = 2'd3
   } fsm_state_type;

   typedef enum logic [1:0] {
      DIR_NONE      = 2'd0,
      DIR_SHED      = 2'd1,
      DIR_RECONNECT = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      CT_IDLE   = 2'd0,
      CT_CALC   = 2'd1,
      CT_FINISH = 2'd2
   } ctrl_state_type;

   typedef enum logic [2:0] {
      AR_IDLE = 3'd0,
      AR_DIV  = 3'd1,
      AR_PREP = 3'd2,
      AR_MUL  = 3'd3,
      AR_SAT  = 3'd4
   } ar_phase_type;

   typedef struct packed {
      logic start;
   } ar_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ar_sts_type;

endpackage

// ===== hw/rtl/fls_arith.sv =====
module fls_arith (
   input  logic                              clock,
   input  logic                              reset,
   input  fls_pkg::ar_ctl_type               ctl,
   input  logic [fls_pkg::COUNT_W-1:0]       raw_count,
   input  logic [fls_pkg::FREQ_W-1:0]        cur_freq,
   output fls_pkg::ar_sts_type               sts,
   output logic [fls_pkg::FREQ_W-1:0]        freq,
   output logic signed [fls_pkg::ROC_W-1:0]  roc
);

   localparam int FW  = fls_pkg::FREQ_W;
   localparam int CW  = fls_pkg::COUNT_W;
   localparam int PW  = fls_pkg::PROD_W;
   localparam int RW  = fls_pkg::ROC_W;
   localparam int SW  = fls_pkg::STEP_W;
   localparam int TOP = RW - 1 + fls_pkg::ROC_SHIFT;

   fls_pkg::ar_phase_type phase_ff, phase_in;
   logic [SW-1:0]         cnt_ff, cnt_in;

   logic [CW:0]    rem_ff, rem_in;
   logic [FW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  dvs_ff, dvs_in;
   logic [FW:0]    mcand_ff, mcand_in;
   logic [FW+1:0]  hi_ff, hi_in;
   logic [FW-1:0]  lo_ff, lo_in;
   logic [RW-1:0]  roc_ff, roc_in;

   logic [CW:0]    rem_sh;
   logic [CW:0]    rem_sub;
   logic           fits;
   logic [FW+1:0]  addend;
   logic [FW+1:0]  psum;
   logic [PW-1:0]  prod;
   logic           in_range;
   logic [RW-1:0]  roc_sat;

   // Restoring division step: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   assign rem_sh  = {rem_ff[CW-1:0], quo_ff[FW-1]};
   assign fits    = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   // Shift-and-add multiply of the signed difference by the unsigned frequency.
   assign addend = lo_ff[0] ? {mcand_ff[FW], mcand_ff} : '0;
   assign psum   = hi_ff + addend;

   // Dropping the low eight bits of a two's complement product is a floor
   // division by 256; the rest is saturated to the 32-bit range.
   assign prod     = {hi_ff, lo_ff};
   assign in_range = (&prod[PW-1:TOP]) || !(|prod[PW-1:TOP]);
   assign roc_sat  = in_range ? prod[TOP:fls_pkg::ROC_SHIFT]
                              : (prod[PW-1] ? {1'b1, {(RW-1){1'b0}}}
                                            : {1'b0, {(RW-1){1'b1}}});

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      roc_in   = roc_ff;
      unique case (phase_ff)
         fls_pkg::AR_IDLE: begin
            if (ctl.start) begin
               phase_in = fls_pkg::AR_DIV;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = fls_pkg::DIVIDEND;
               dvs_in   = raw_count;
            end
         end
         fls_pkg::AR_DIV: begin
            rem_in = fits ? rem_sub : rem_sh;
            quo_in = {quo_ff[FW-2:0], fits};
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(fls_pkg::DIV_STEPS - 1)) begin
               phase_in = fls_pkg::AR_PREP;
            end
         end
         fls_pkg::AR_PREP: begin
            mcand_in = {1'b0, quo_ff} - {1'b0, cur_freq};
            hi_in    = '0;
            lo_in    = quo_ff;
            cnt_in   = '0;
            phase_in = fls_pkg::AR_MUL;
         end
         fls_pkg::AR_MUL: begin
            hi_in  = {psum[FW+1], psum[FW+1:1]};
            lo_in  = {psum[0], lo_ff[FW-1:1]};
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(fls_pkg::MUL_STEPS - 1)) begin
               phase_in = fls_pkg::AR_SAT;
            end
         end
         fls_pkg::AR_SAT: begin
            roc_in   = roc_sat;
            phase_in = fls_pkg::AR_IDLE;
         end
         default: begin
            phase_in = fls_pkg::AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fls_pkg::AR_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      roc_ff   <= roc_in;
   end

   assign sts.busy = (phase_ff != fls_pkg::AR_IDLE);
   assign sts.done = (phase_ff == fls_pkg::AR_SAT);
   assign freq     = quo_ff;
   assign roc      = roc_ff;

endmodule

// ===== hw/rtl/frequency_load_shed_controller.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_kind, req_raw_count
// rsp       out        rsp_valid/rsp_stall load_mask, frequency, rate_of_change,
//                                          machine_state, restart_timer, bad_count
// csr       in/out     psel/penable/pready freq_threshold @0x0, roc_threshold @0x4
//
// For a frequency sample the serial divider produces one quotient bit a cycle, then the
// serial multiplier consumes one frequency bit a cycle, followed by set-up, saturation
// and commit. Timer requests and zero counts skip the arithmetic and go to commit.
// One request is worked on at a time; req_stall is high while it is in progress.
// A result waiting on rsp_stall does not block acceptance of the next request;
// only the commit of that request waits for the output register to free.
// Reset is synchronous and restores the thresholds and the relay state.
module frequency_load_shed_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [fls_pkg::COUNT_W-1:0]       req_raw_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fls_pkg::MASK_W-1:0]        rsp_load_mask,
   output logic [fls_pkg::FREQ_W-1:0]        rsp_frequency,
   output logic signed [fls_pkg::ROC_W-1:0]  rsp_rate_of_change,
   output logic [fls_pkg::STATE_W-1:0]       rsp_machine_state,
   output logic                              rsp_restart_timer,
   output logic                              rsp_bad_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fls_pkg::ADDR_W-1:0]        paddr,
   input  logic [fls_pkg::DATA_W-1:0]        pwdata,
   output logic [fls_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   localparam int FW = fls_pkg::FREQ_W;
   localparam int RW = fls_pkg::ROC_W;
   localparam int MW = fls_pkg::MASK_W;
   localparam int HW = fls_pkg::SHED_W;

   // Configuration registers.
   logic [FW-1:0]         fthr_ff;
   logic signed [RW-1:0]  rthr_ff;
   logic                  csr_write;

   // Request control.
   fls_pkg::ctrl_state_type ctrl_ff, ctrl_in;
   logic                    kind_ff;
   logic                    bad_ff;
   logic                    accept;
   logic                    sample_ok;
   logic                    slot_free;
   logic                    commit;

   // Arithmetic unit.
   fls_pkg::ar_ctl_type   ar_ctl;
   fls_pkg::ar_sts_type   ar_sts;
   logic [FW-1:0]         ar_freq;
   logic signed [RW-1:0]  ar_roc;

   // Relay state.
   fls_pkg::fsm_state_type fsm_state_ff, fsm_state_in;
   fls_pkg::dir_type       dir_ff, dir_in;
   logic                   timeout_ff, timeout_in;
   logic [HW-1:0]          shed_count_ff, shed_count_in;
   logic [MW-1:0]          mask_ff, mask_in;
   logic [FW-1:0]          cur_freq_ff;

   logic [FW-1:0]          f_sel;
   logic signed [RW-1:0]   roc_sel;
   logic                   timeout_eff;
   logic                   unstable;
   logic                   recovering;
   logic                   restart;
   logic [HW-1:0]          shed_dec;

   // Output register.
   logic                   rsp_valid_ff;
   logic [MW-1:0]          rsp_mask_ff;
   logic [FW-1:0]          rsp_freq_ff;
   logic signed [RW-1:0]   rsp_roc_ff;
   logic [fls_pkg::STATE_W-1:0] rsp_state_ff;
   logic                   rsp_restart_ff;
   logic                   rsp_bad_ff;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == fls_pkg::REG_ROC_THR) ? rthr_ff
                                                         : {{(32-FW){1'b0}}, fthr_ff};

   // --------------------------------------------------------------- control
   assign accept    = req_valid && !req_stall;
   assign sample_ok = (req_kind == fls_pkg::KIND_SAMPLE) && (req_raw_count != '0);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctrl_in      = ctrl_ff;
      req_stall    = 1'b1;
      ar_ctl.start = 1'b0;
      commit       = 1'b0;
      unique case (ctrl_ff)
         fls_pkg::CT_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ar_ctl.start = sample_ok;
               ctrl_in      = sample_ok ? fls_pkg::CT_CALC : fls_pkg::CT_FINISH;
            end
         end
         fls_pkg::CT_CALC: begin
            if (ar_sts.done) begin
               ctrl_in = fls_pkg::CT_FINISH;
            end
         end
         fls_pkg::CT_FINISH: begin
            if (slot_free) begin
               commit  = 1'b1;
               ctrl_in = fls_pkg::CT_IDLE;
            end
         end
         default: begin
            ctrl_in = fls_pkg::CT_IDLE;
         end
      endcase
   end

   fls_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ar_ctl),
      .raw_count (req_raw_count),
      .cur_freq  (cur_freq_ff),
      .sts       (ar_sts),
      .freq      (ar_freq),
      .roc       (ar_roc)
   );

   // ------------------------------------------------------------ relay logic
   // A timer request keeps the frequency, counts as a rate of zero and marks
   // the timeout before the transition is decided.
   assign f_sel       = (kind_ff == fls_pkg::KIND_TIMER) ? cur_freq_ff : ar_freq;
   assign roc_sel     = (kind_ff == fls_pkg::KIND_TIMER) ? '0 : ar_roc;
   assign timeout_eff = timeout_ff || (kind_ff == fls_pkg::KIND_TIMER);
   assign unstable    = (f_sel < fthr_ff) || (roc_sel > rthr_ff);
   assign recovering  = (f_sel > fthr_ff) || (roc_sel < rthr_ff);
   assign shed_dec    = shed_count_ff - HW'(1);

   always_comb begin
      fsm_state_in  = fsm_state_ff;
      dir_in        = dir_ff;
      timeout_in    = timeout_eff;
      shed_count_in = shed_count_ff;
      mask_in       = mask_ff;
      restart       = 1'b0;

      unique case (fsm_state_ff)
         fls_pkg::ST_STABLE: begin
            fsm_state_in = unstable ? fls_pkg::ST_SHED : fls_pkg::ST_STABLE;
         end
         fls_pkg::ST_SHED: begin
            fsm_state_in = fls_pkg::ST_MONITOR;
         end
         fls_pkg::ST_MONITOR: begin
            if (timeout_eff && (dir_ff == fls_pkg::DIR_SHED)) begin
               fsm_state_in = fls_pkg::ST_SHED;
            end else if (timeout_eff && (dir_ff == fls_pkg::DIR_RECONNECT)) begin
               fsm_state_in = fls_pkg::ST_RECONNECT;
            end
         end
         fls_pkg::ST_RECONNECT: begin
            fsm_state_in = (shed_count_ff == '0) ? fls_pkg::ST_STABLE
                                                 : fls_pkg::ST_MONITOR;
         end
         default: begin
            fsm_state_in = fls_pkg::ST_STABLE;
         end
      endcase

      unique case (fsm_state_in)
         fls_pkg::ST_SHED: begin
            // Loads go lowest index first; with all of them off nothing moves.
            if (shed_count_ff < HW'(fls_pkg::NUM_LOADS)) begin
               mask_in       = mask_ff & ~(MW'(1) << shed_count_ff[2:0]);
               shed_count_in = shed_count_ff + HW'(1);
            end
            dir_in     = fls_pkg::DIR_NONE;
            timeout_in = 1'b0;
         end
         fls_pkg::ST_MONITOR: begin
            if (dir_ff == fls_pkg::DIR_NONE) begin
               dir_in  = unstable ? fls_pkg::DIR_SHED : fls_pkg::DIR_RECONNECT;
               restart = 1'b1;
            end else if ((dir_ff == fls_pkg::DIR_SHED) && recovering) begin
               dir_in  = fls_pkg::DIR_RECONNECT;
               restart = 1'b1;
            end else if ((dir_ff == fls_pkg::DIR_RECONNECT) && unstable) begin
               dir_in  = fls_pkg::DIR_SHED;
               restart = 1'b1;
            end
         end
         fls_pkg::ST_RECONNECT: begin
            // Restored in reverse order: the most recently shed load first.
            if (shed_count_ff != '0) begin
               shed_count_in = shed_dec;
               mask_in       = mask_ff | (MW'(1) << shed_dec[2:0]);
            end
            dir_in     = fls_pkg::DIR_NONE;
            timeout_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fthr_ff       <= fls_pkg::FREQ_THR_RESET;
         rthr_ff       <= fls_pkg::ROC_THR_RESET;
         ctrl_ff       <= fls_pkg::CT_IDLE;
         fsm_state_ff  <= fls_pkg::ST_STABLE;
         dir_ff        <= fls_pkg::DIR_NONE;
         timeout_ff    <= 1'b0;
         shed_count_ff <= '0;
         mask_ff       <= '1;
         cur_freq_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
         if (csr_write) begin
            if (paddr[2] == fls_pkg::REG_ROC_THR) begin
               rthr_ff <= pwdata;
            end else begin
               fthr_ff <= pwdata[FW-1:0];
            end
         end
         if (commit && !bad_ff) begin
            fsm_state_ff  <= fsm_state_in;
            dir_ff        <= dir_in;
            timeout_ff    <= timeout_in;
            shed_count_ff <= shed_count_in;
            mask_ff       <= mask_in;
            cur_freq_ff   <= f_sel;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         bad_ff  <= (req_kind == fls_pkg::KIND_SAMPLE) && (req_raw_count == '0);
      end
      if (commit) begin
         if (bad_ff) begin
            rsp_mask_ff    <= mask_ff;
            rsp_freq_ff    <= cur_freq_ff;
            rsp_roc_ff     <= '0;
            rsp_state_ff   <= fsm_state_ff;
            rsp_restart_ff <= 1'b0;
            rsp_bad_ff     <= 1'b1;
         end else begin
            rsp_mask_ff    <= mask_in;
            rsp_freq_ff    <= f_sel;
            rsp_roc_ff     <= roc_sel;
            rsp_state_ff   <= fsm_state_in;
            rsp_restart_ff <= restart;
            rsp_bad_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_load_mask      = rsp_mask_ff;
   assign rsp_frequency      = rsp_freq_ff;
   assign rsp_rate_of_change = rsp_roc_ff;
   assign rsp_machine_state  = rsp_state_ff;
   assign rsp_restart_timer  = rsp_restart_ff;
   assign rsp_bad_count      = rsp_bad_ff;

   // ------------------------------------------------------------ assertions
   // The connected loads plus shed_count always add up to the mask width.
   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      ($countones(mask_ff) + int'(shed_count_ff)) == MW)
      else $error("connected mask disagrees with shed count");

   a_shed_bound: assert property (@(posedge clock) disable iff (reset)
      shed_count_ff <= HW'(fls_pkg::NUM_LOADS))
      else $error("shed count beyond number of loads");

   // Stable is only reached once every shed load is back.
   a_stable_restored: assert property (@(posedge clock) disable iff (reset)
      (fsm_state_ff == fls_pkg::ST_STABLE) |-> (shed_count_ff == '0))
      else $error("stable state with loads still shed");

   a_arith_owned: assert property (@(posedge clock) disable iff (reset)
      ar_sts.busy |-> (ctrl_ff == fls_pkg::CT_CALC))
      else $error("arithmetic unit busy outside calculation");

   a_commit_shown: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("committed result not presented");

endmodule

// ===== tb/fls_result_checker.sv =====
`timescale 1ns / 1ps

module fls_result_checker
   import fls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_kind,
   input  logic [COUNT_W-1:0]       req_raw_count,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [MASK_W-1:0]        rsp_load_mask,
   input  logic [FREQ_W-1:0]        rsp_frequency,
   input  logic signed [ROC_W-1:0]  rsp_rate_of_change,
   input  logic [STATE_W-1:0]       rsp_machine_state,
   input  logic                     rsp_restart_timer,
   input  logic                     rsp_bad_count,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   input  logic                     pready,
   output int unsigned              error_count,
   output int unsigned              pending_count
);

   localparam longint RATE_MAX = 64'sd2147483647;
   localparam longint RATE_MIN = -RATE_MAX - 64'sd1;

   typedef struct packed {
      logic [MASK_W-1:0]        mask;
      logic [FREQ_W-1:0]        freq;
      logic signed [ROC_W-1:0]  rate;
      logic [STATE_W-1:0]       state;
      logic                     restart;
      logic                     bad;
   } relay_result_t;

   // Thresholds and relay state as the block should hold them.
   logic [FREQ_W-1:0]  freq_limit;
   logic [ROC_W-1:0]   rate_limit;
   logic [FREQ_W-1:0]  last_freq;
   fsm_state_type      relay_state;
   dir_type            watch_dir;
   logic               timer_expired;
   logic [SHED_W-1:0]  loads_shed;
   logic [MASK_W-1:0]  connected;

   relay_result_t      relay_predictions[$];
   relay_result_t      seen;
   relay_result_t      want;

   function automatic relay_result_t advance_relay(input logic kind,
                                                   input logic [COUNT_W-1:0] count);
      relay_result_t      r;
      logic [FREQ_W-1:0]  f;
      longint             delta;
      longint             rate;
      longint             limit;
      logic               unstable;
      logic               recovering;
      fsm_state_type      next_state;
      r = '0;
      rate = 0;
      // A zero period count is only flagged; nothing in the relay moves.
      if (kind == KIND_SAMPLE && count == '0) begin
         r.mask = connected;
         r.freq = last_freq;
         r.state = relay_state;
         r.bad = 1'b1;
         return r;
      end
      if (kind == KIND_TIMER) begin
         timer_expired = 1'b1;
         f = last_freq;
      end else begin
         f = DIVIDEND / count;
         delta = longint'(f) - longint'(last_freq);
         rate = (delta * longint'(f)) >>> ROC_SHIFT;
         if (rate > RATE_MAX) rate = RATE_MAX;
         if (rate < RATE_MIN) rate = RATE_MIN;
         last_freq = f;
      end
      limit = longint'($signed(rate_limit));
      unstable = (f < freq_limit) || (rate > limit);
      recovering = (f > freq_limit) || (rate < limit);

      case (relay_state)
         ST_STABLE: begin
            if (unstable) next_state = ST_SHED;
            else next_state = ST_STABLE;
         end
         ST_SHED: next_state = ST_MONITOR;
         ST_MONITOR: begin
            next_state = ST_MONITOR;
            if (timer_expired) begin
               if (watch_dir == DIR_SHED) next_state = ST_SHED;
               else if (watch_dir == DIR_RECONNECT) next_state = ST_RECONNECT;
            end
         end
         default: begin
            if (loads_shed == '0) next_state = ST_STABLE;
            else next_state = ST_MONITOR;
         end
      endcase

      case (next_state)
         ST_SHED: begin
            // With every load already off, shedding again leaves the mask alone.
            if (loads_shed < NUM_LOADS) begin
               connected = connected & ~(MASK_W'(1) << loads_shed);
               loads_shed = loads_shed + 1'b1;
            end
            watch_dir = DIR_NONE;
            timer_expired = 1'b0;
         end
         ST_MONITOR: begin
            case (watch_dir)
               DIR_NONE: begin
                  if (unstable) watch_dir = DIR_SHED;
                  else watch_dir = DIR_RECONNECT;
                  r.restart = 1'b1;
               end
               DIR_SHED: begin
                  if (recovering) begin
                     watch_dir = DIR_RECONNECT;
                     r.restart = 1'b1;
                  end
               end
               DIR_RECONNECT: begin
                  if (unstable) begin
                     watch_dir = DIR_SHED;
                     r.restart = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_RECONNECT: begin
            // Loads come back in the reverse of the order they went.
            if (loads_shed != '0) begin
               loads_shed = loads_shed - 1'b1;
               connected = connected | (MASK_W'(1) << loads_shed[2:0]);
            end
            watch_dir = DIR_NONE;
            timer_expired = 1'b0;
         end
         default: ;
      endcase
      relay_state = next_state;

      r.mask = connected;
      r.freq = f;
      r.rate = ROC_W'(rate);
      r.state = relay_state;
      return r;
   endfunction

   task automatic compare_field(input string name, input longint want_v,
                                input longint got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         freq_limit = FREQ_THR_RESET;
         rate_limit = ROC_THR_RESET;
         last_freq = '0;
         relay_state = ST_STABLE;
         watch_dir = DIR_NONE;
         timer_expired = 1'b0;
         loads_shed = '0;
         connected = '1;
         error_count = 0;
         relay_predictions.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ROC_THR) rate_limit = pwdata;
            else freq_limit = pwdata[FREQ_W-1:0];
         end
         if (req_valid && !req_stall) begin
            relay_predictions.push_back(advance_relay(req_kind, req_raw_count));
         end
         if (rsp_valid && !rsp_stall) begin
            seen.mask = rsp_load_mask;
            seen.freq = rsp_frequency;
            seen.rate = rsp_rate_of_change;
            seen.state = rsp_machine_state;
            seen.restart = rsp_restart_timer;
            seen.bad = rsp_bad_count;
            if (relay_predictions.size() == 0) begin
               $display("%0t: unexpected result, expected none, got mask %h freq %0d state %0d",
                        $time, seen.mask, seen.freq, seen.state);
               error_count++;
            end else begin
               want = relay_predictions.pop_front();
               compare_field("load_mask", longint'(want.mask), longint'(seen.mask));
               compare_field("frequency", longint'(want.freq), longint'(seen.freq));
               compare_field("rate_of_change", longint'($signed(want.rate)),
                             longint'($signed(seen.rate)));
               compare_field("machine_state", longint'(want.state), longint'(seen.state));
               compare_field("restart_timer", longint'(want.restart),
                             longint'(seen.restart));
               compare_field("bad_count", longint'(want.bad), longint'(seen.bad));
            end
         end
      end
      pending_count <= relay_predictions.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import fls_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int NUM_PHASES       = 6;
   localparam int RANDOM_PER_PHASE = 85;
   localparam int DRAIN_CYCLES     = 60;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HOLD
   } stall_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_kind = KIND_SAMPLE;
   logic [COUNT_W-1:0]       req_raw_count = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MASK_W-1:0]        rsp_load_mask;
   logic [FREQ_W-1:0]        rsp_frequency;
   logic signed [ROC_W-1:0]  rsp_rate_of_change;
   logic [STATE_W-1:0]       rsp_machine_state;
   logic                     rsp_restart_timer;
   logic                     rsp_bad_count;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   int unsigned              error_count;
   int unsigned              pending_count;

   int                       burst_left = 0;
   int                       mains_count = 360;
   int                       sent_total = 0;
   int                       sent_timer = 0;
   int                       sent_zero = 0;
   int unsigned              cycle_count = 0;
   stall_mode_type           stall_mode = STALL_NONE;
   int                       stall_left = 0;

   frequency_load_shed_controller dut (.*);

   fls_result_checker relay_check (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver switches between free flow, scattered stalls and unbroken holds.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         if (stall_mode == STALL_HOLD) stall_left = $urandom_range(1, 25);
         else stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(input logic kind, input logic [COUNT_W-1:0] count);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) gap = $urandom_range(10, 60);
         else gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 80);
         else burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_raw_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_total++;
      if (kind == KIND_TIMER) sent_timer++;
      else if (count == '0) sent_zero++;
   endtask

   // Mostly mains-like periods that drift around the threshold, with timer
   // expiries mixed in, plus some wild and zero counts as noise.
   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         send_request(KIND_TIMER, COUNT_W'($urandom));
      end else if (pick < 31) begin
         send_request(KIND_SAMPLE, '0);
      end else if (pick < 41) begin
         send_request(KIND_SAMPLE, COUNT_W'($urandom));
      end else begin
         if ($urandom_range(0, 9) == 0) mains_count = $urandom_range(300, 420);
         else mains_count = mains_count + int'($urandom_range(0, 6)) - 3;
         if (mains_count < 280) mains_count = 280;
         if (mains_count > 440) mains_count = 440;
         send_request(KIND_SAMPLE, COUNT_W'(mains_count));
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_thresholds(input int phase);
      logic [DATA_W-1:0] freq_value;
      logic [DATA_W-1:0] rate_value;
      case (phase)
         0: begin
            freq_value = DATA_W'(FREQ_THR_RESET);
            rate_value = ROC_THR_RESET;
         end
         1: begin
            freq_value = '0;
            rate_value = 32'h8000_0000;
         end
         2: begin
            freq_value = DATA_W'(22'h3F_FFFF);
            rate_value = 32'h7FFF_FFFF;
         end
         3: begin
            freq_value = $urandom_range(11000, 13500);
            rate_value = $urandom_range(0, 3000);
         end
         4: begin
            freq_value = $urandom & 32'h003F_FFFF;
            rate_value = $urandom;
         end
         default: begin
            freq_value = $urandom_range(12000, 13000);
            rate_value = -DATA_W'($urandom_range(0, 500));
         end
      endcase
      write_register(REG_FREQ_THR, freq_value);
      write_register(REG_ROC_THR, rate_value);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first sample sees a previous frequency of zero and so a huge rate.
      send_request(KIND_SAMPLE, COUNT_W'(320));
      send_request(KIND_SAMPLE, '0);
      send_request(KIND_SAMPLE, 16'hFFFF);
      send_request(KIND_TIMER, 16'hFFFF);
      send_request(KIND_SAMPLE, COUNT_W'(1));
      send_request(KIND_TIMER, '0);
      // Low frequency with repeated expiries sheds every load and then tries twice more.
      repeat (7) begin
         send_request(KIND_SAMPLE, COUNT_W'(1000));
         send_request(KIND_TIMER, COUNT_W'($urandom));
      end
      // Back to normal mains so that loads start to come back.
      send_request(KIND_SAMPLE, COUNT_W'(320));
      send_request(KIND_SAMPLE, COUNT_W'(320));
      send_request(KIND_TIMER, '0);
      send_request(KIND_SAMPLE, COUNT_W'(320));
      wait_until_idle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         apply_thresholds(phase);
         repeat (RANDOM_PER_PHASE) send_random_request();
         wait_until_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d timer expiries, %0d zero counts) under %0d settings",
               sent_total, sent_timer, sent_zero, NUM_PHASES + 1);
      $display("of the two thresholds, extremes included, with random gaps and stalls.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fls_pkg.sv
hw/rtl/fls_arith.sv
hw/rtl/frequency_load_shed_controller.sv
tb/fls_result_checker.sv
tb/tb_top.sv
